@@ rtl/life_grid_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// life_grid_engine_unit_defines
// assertion helpers used by the checker file lge_checker
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_ENGINE_UNIT_DEFINES_SVH
`define LIFE_GRID_ENGINE_UNIT_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define LGE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lge check failed");

// next-cycle implication
`define LGE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lge check failed");

`endif

@@ rtl/lge_pkg.sv @@
// ----------------------------------------------------------------------------
// lge_pkg
// types, codes and rule helpers for the life grid engine
// ----------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

   localparam int GRID_ROWS_DEF = 64;
   localparam int GRID_COLS_DEF = 64;

   // transaction field widths
   localparam int KIND_W   = 2;
   localparam int FIELD_W  = 6;
   // wide enough to compare a field against any row or column up to 511
   localparam int INDEX_W  = 9;

   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STEP  = 2'd2;

   typedef struct packed {
      logic shift;    // take the row handed over by the neighbor
      logic wr;       // this cell holds the addressed row
      logic wr_bit;   // value written to the selected column
   } cell_ctl_type;

   function automatic logic [3:0] count8(input logic [7:0] nb);
      logic [3:0] s;
      s = 4'd0;
      for (int k = 0; k < 8; k++) begin
         s = s + {3'd0, nb[k]};
      end
      return s;
   endfunction

   // b3/s23
   function automatic logic next_state(input logic alive, input logic [3:0] sum);
      logic r;
      if (alive) begin
         r = (sum == 4'd2) || (sum == 4'd3);
      end else begin
         r = (sum == 4'd3);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/lge_row_cell.sv @@
// ----------------------------------------------------------------------------
// lge_row_cell
// one grid row: takes its neighbor's row during a generation, else a cell write
// ----------------------------------------------------------------------------
`default_nettype none

module lge_row_cell #(
   parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lge_pkg::cell_ctl_type ctl,
   input  wire logic [GRID_COLS-1:0] col_sel,
   input  wire logic [GRID_COLS-1:0] shift_row,
   output logic      [GRID_COLS-1:0] row_out
);

   logic [GRID_COLS-1:0] row_ff;
   logic [GRID_COLS-1:0] row_in;

   always_comb begin
      priority if (ctl.shift) begin
         row_in = shift_row;
      end else if (ctl.wr) begin
         row_in = (row_ff & ~col_sel) | (col_sel & {GRID_COLS{ctl.wr_bit}});
      end else begin
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_out = row_ff;

endmodule

`default_nettype wire

@@ rtl/lge_next_row.sv @@
// ----------------------------------------------------------------------------
// lge_next_row
// next generation of one row from the old rows above, at and below it
// ----------------------------------------------------------------------------
`default_nettype none

module lge_next_row #(
   parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
   input  wire logic [GRID_COLS-1:0] above,
   input  wire logic [GRID_COLS-1:0] cur,
   input  wire logic [GRID_COLS-1:0] below,
   output logic      [GRID_COLS-1:0] next_row
);

   // one dead column on each side
   logic [GRID_COLS+1:0] a_pad;
   logic [GRID_COLS+1:0] c_pad;
   logic [GRID_COLS+1:0] b_pad;

   assign a_pad = {1'b0, above, 1'b0};
   assign c_pad = {1'b0, cur, 1'b0};
   assign b_pad = {1'b0, below, 1'b0};

   for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
      logic [7:0] nb;
      assign nb = {a_pad[c], a_pad[c+1], a_pad[c+2],
                   c_pad[c],             c_pad[c+2],
                   b_pad[c], b_pad[c+1], b_pad[c+2]};
      assign next_row[c] = lge_pkg::next_state(cur[c], lge_pkg::count8(nb));
   end

endmodule

`default_nettype wire

@@ rtl/life_grid_engine_unit.sv @@
// ----------------------------------------------------------------------------
// life_grid_engine_unit
// game of life grid (b3/s23, dead border) with cell write, read and step
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one transaction: kind write, read or step, with row, col
//   and cell_in. rsp_* returns one transaction per request: rsp_cell_out is
//   the cell for a read, 0 otherwise; rsp_step_done is 1 for a step.
//   write and read: response valid in the cycle after the request is taken.
//   step: the rows sit in a chain of row cells that shifts by one row per
//   cycle through the next-row logic, and the response shows with the last
//   shift of a full turn of the chain. req_ready is low during the step.
//   throughput: 1 transaction per cycle for read and write while the
//   response side keeps up; a step blocks new requests until its last shift.
//   reset clears all cells, the saved row and the response valid flag.
//   a stalled response holds its data and blocks new requests until taken;
//   a request is still taken in the cycle its predecessor's response leaves.
//   indexes beyond the grid size are ignored by writes and read back as 0.
// ----------------------------------------------------------------------------
`default_nettype none

module life_grid_engine_unit #(
   parameter int GRID_ROWS = lge_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = lge_pkg::GRID_COLS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [lge_pkg::KIND_W-1:0]  req_kind,
   input  wire logic [lge_pkg::FIELD_W-1:0] req_row,
   input  wire logic [lge_pkg::FIELD_W-1:0] req_col,
   input  wire logic                        req_cell_in,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_cell_out,
   output logic                             rsp_step_done
);

   localparam int CNT_W = $clog2(GRID_ROWS);
   localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GRID_ROWS - 1);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [GRID_COLS-1:0] saved_ff, saved_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_cell_ff, rsp_cell_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic                 req_take;
   logic [lge_pkg::INDEX_W-1:0] row_ext;
   logic [lge_pkg::INDEX_W-1:0] col_ext;
   logic [GRID_COLS-1:0] col_sel;
   logic [GRID_ROWS-1:0] row_hit;
   logic [GRID_ROWS-1:0] row_rd;
   logic                 rd_bit;
   logic                 do_write;
   logic [GRID_COLS-1:0] below_row;
   logic [GRID_COLS-1:0] new_row;

   logic [GRID_COLS-1:0] row_q [GRID_ROWS];

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;
   assign do_write  = req_take && (req_kind == lge_pkg::KIND_WRITE);

   assign row_ext = {{(lge_pkg::INDEX_W - lge_pkg::FIELD_W){1'b0}}, req_row};
   assign col_ext = {{(lge_pkg::INDEX_W - lge_pkg::FIELD_W){1'b0}}, req_col};

   for (genvar j = 0; j < GRID_COLS; j++) begin : g_colsel
      assign col_sel[j] = (col_ext == lge_pkg::INDEX_W'(j));
   end

   // chain of row cells: cell i takes cell i+1, the last takes the new row
   for (genvar i = 0; i < GRID_ROWS; i++) begin : g_cell
      lge_pkg::cell_ctl_type ctl;
      logic [GRID_COLS-1:0]  shift_src;

      assign row_hit[i] = (row_ext == lge_pkg::INDEX_W'(i));
      assign row_rd[i]  = row_hit[i] && |(row_q[i] & col_sel);
      assign ctl.shift  = busy_ff;
      assign ctl.wr     = do_write && row_hit[i];
      assign ctl.wr_bit = req_cell_in;

      if (i == GRID_ROWS - 1) begin : g_tail
         assign shift_src = new_row;
      end else begin : g_body
         assign shift_src = row_q[i+1];
      end

      lge_row_cell #(
         .GRID_COLS (GRID_COLS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .col_sel   (col_sel),
         .shift_row (shift_src),
         .row_out   (row_q[i])
      );
   end

   assign rd_bit = |row_rd;

   // the head cell holds the row being updated, the next one the row below
   assign below_row = (cnt_ff == LAST_ROW) ? '0 : row_q[1];

   lge_next_row #(
      .GRID_COLS (GRID_COLS)
   ) u_next (
      .above    (saved_ff),
      .cur      (row_q[0]),
      .below    (below_row),
      .next_row (new_row)
   );

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      saved_in     = saved_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_done_in  = rsp_done_ff;

      if (busy_ff) begin
         saved_in = row_q[0];
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == LAST_ROW) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_cell_in  = 1'b0;
            rsp_done_in  = 1'b1;
         end
      end else if (req_take) begin
         if (req_kind == lge_pkg::KIND_STEP) begin
            busy_in  = 1'b1;
            cnt_in   = '0;
            saved_in = '0;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_cell_in  = (req_kind == lge_pkg::KIND_READ) && rd_bit;
            rsp_done_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         saved_ff     <= saved_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cell_ff <= rsp_cell_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cell_out  = rsp_cell_ff;
   assign rsp_step_done = rsp_done_ff;

endmodule

`default_nettype wire

@@ rtl/lge_checker.sv @@
// ----------------------------------------------------------------------------
// lge_checker
// port-level checks on the life grid engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "life_grid_engine_unit_defines.svh"

module lge_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic [lge_pkg::KIND_W-1:0]  req_kind,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_cell_out,
   input wire logic                        rsp_step_done
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // a response never carries both a read value and a step flag
   `LGE_ASSERT_NOW(a_rsp_excl, rsp_valid, !(rsp_cell_out && rsp_step_done))

   // no request slips in while a response is stuck
   `LGE_ASSERT_NOW(a_no_take_on_stall, rsp_valid && !rsp_ready, !req_ready)

   // write and read answer in the next cycle, without a step flag
   `LGE_ASSERT_NEXT(a_rw_rsp,
      req_take && (req_kind == lge_pkg::KIND_WRITE || req_kind == lge_pkg::KIND_READ),
      rsp_valid && !rsp_step_done)

   // a step keeps the engine closed, with no response, in the cycle after it is taken
   `LGE_ASSERT_NEXT(a_step_busy, req_take && (req_kind == lge_pkg::KIND_STEP),
      !rsp_valid && !req_ready)

   // stalled response holds
   `LGE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_cell_out) && $stable(rsp_step_done))

endmodule

bind life_grid_engine_unit lge_checker u_lge_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_kind      (req_kind),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_cell_out  (rsp_cell_out),
   .rsp_step_done (rsp_step_done)
);

`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the life grid engine: cell writes, reads and b3/s23 steps
// ----------------------------------------------------------------------------
// Requests are driven on the req_ channel and every response is checked
// against a shadow copy of the grid. That copy is advanced one generation at
// a time, with a dead border, for each accepted step. Stimulus has four
// parts. A directed part covers the corners, the grid edges and the unused
// kind. Random bursts then load small patterns, step them and read them back.
// A long response hold-off fills the block. Both sides idle at random,
// except in the last stretch.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int ROWS = lge_pkg::GRID_ROWS_DEF;
   localparam int COLS = lge_pkg::GRID_COLS_DEF;

   typedef logic [lge_pkg::KIND_W-1:0]  kind_type;
   typedef logic [lge_pkg::FIELD_W-1:0] field_type;

   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int ITEMS_RANDOM = 950;
   localparam int ITEMS_TOTAL = 1250;

   typedef struct packed {
      logic alive;
      logic done;
   } cell_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   kind_type req_kind = '0;
   field_type req_row = '0;
   field_type req_col = '0;
   logic req_cell_in = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_cell_out;
   logic rsp_step_done;

   logic [COLS-1:0] shadow_grid [ROWS];
   cell_result_type pending_results [$];

   bit idling_enabled = 1'b1;
   bit hold_rsp_request = 1'b0;
   bit hold_rsp_active = 1'b0;
   int items_sent = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int writes_seen = 0;
   int reads_seen = 0;
   int live_reads = 0;
   int steps_seen = 0;
   int unused_seen = 0;

   life_grid_engine_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_cell_in   (req_cell_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_out  (rsp_cell_out),
      .rsp_step_done (rsp_step_done)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // shadow grid
   // ------------------------------------------------------------------------

   // one generation, all cells from the old grid, cells off the edge are dead
   function automatic void advance_shadow_grid();
      logic [COLS-1:0] old_grid [ROWS];
      int sum;
      int rr;
      int cc;
      for (int r = 0; r < ROWS; r++) begin
         old_grid[r] = shadow_grid[r];
      end
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            sum = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  rr = r + dr;
                  cc = c + dc;
                  if ((dr != 0 || dc != 0) && rr >= 0 && rr < ROWS && cc >= 0 && cc < COLS) begin
                     sum += old_grid[rr][cc];
                  end
               end
            end
            if (old_grid[r][c]) begin
               shadow_grid[r][c] = (sum == 2) || (sum == 3);
            end else begin
               shadow_grid[r][c] = (sum == 3);
            end
         end
      end
   endfunction

   function automatic cell_result_type predict_cell_result(input kind_type kind,
                                                           input field_type row,
                                                           input field_type col,
                                                           input logic cell_val);
      cell_result_type res;
      bit in_grid;
      res = '0;
      in_grid = (int'(row) < ROWS) && (int'(col) < COLS);
      case (kind)
         lge_pkg::KIND_WRITE: begin
            writes_seen++;
            if (in_grid) begin
               shadow_grid[row][col] = cell_val;
            end
         end
         lge_pkg::KIND_READ: begin
            reads_seen++;
            if (in_grid) begin
               res.alive = shadow_grid[row][col];
            end
            if (res.alive) begin
               live_reads++;
            end
         end
         lge_pkg::KIND_STEP: begin
            steps_seen++;
            advance_shadow_grid();
            res.done = 1'b1;
         end
         default: begin
            unused_seen++;
         end
      endcase
      return res;
   endfunction

   function automatic void log_error(input string msg);
      error_count++;
      if (error_count <= 10) begin
         $display("error: %s", msg);
      end
   endfunction

   initial begin
      for (int r = 0; r < ROWS; r++) begin
         shadow_grid[r] = '0;
      end
   end

   // responses are checked before the request of the same edge is predicted
   always @(posedge clock) begin : result_checker
      cell_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               log_error($sformatf("response with nothing pending: cell %0b done %0b",
                                   rsp_cell_out, rsp_step_done));
            end else begin
               want = pending_results.pop_front();
               if (rsp_cell_out !== want.alive || rsp_step_done !== want.done) begin
                  log_error($sformatf("expected cell %0b done %0b, got cell %0b done %0b",
                                      want.alive, want.done, rsp_cell_out, rsp_step_done));
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(
               predict_cell_result(req_kind, req_row, req_col, req_cell_in));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------------

   initial begin : rsp_driver
      int hold_count;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_request) begin
            hold_rsp_request = 1'b0;
            hold_rsp_active = 1'b1;
            rsp_ready <= 1'b0;
            hold_count = 0;
            while (hold_count < LONG_HOLD_CYCLES) begin
               @(posedge clock);
               hold_count++;
            end
            hold_rsp_active = 1'b0;
         end else if (idling_enabled && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   task automatic send_item(input kind_type kind, input field_type row,
                            input field_type col, input logic cell_val);
      if (idling_enabled && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_row <= row;
      req_col <= col;
      req_cell_in <= cell_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   function automatic int pick_origin(input int span, input int limit);
      int pick;
      case ($urandom_range(0, 3))
         0: pick = 0;
         1: pick = limit - span;
         default: pick = $urandom_range(0, limit - span);
      endcase
      return pick;
   endfunction

   function automatic int clip_index(input int idx, input int limit);
      return (idx < 0) ? 0 : ((idx >= limit) ? limit - 1 : idx);
   endfunction

   // load a small random patch, step it a few times and read it back
   task automatic run_pattern_burst();
      int h;
      int w;
      int r0;
      int c0;
      int rr;
      int cc;
      h = $urandom_range(3, 7);
      w = $urandom_range(3, 7);
      r0 = pick_origin(h, ROWS);
      c0 = pick_origin(w, COLS);
      for (int i = 0; i < h; i++) begin
         for (int j = 0; j < w; j++) begin
            // some cells keep what earlier bursts left
            if ($urandom_range(0, 3) != 0) begin
               rr = r0 + i;
               cc = c0 + j;
               send_item(lge_pkg::KIND_WRITE, field_type'(rr), field_type'(cc),
                         1'($urandom_range(0, 1)));
            end
         end
      end
      repeat ($urandom_range(1, 3)) begin
         // row, col and cell_in are don't-care for a step
         send_item(lge_pkg::KIND_STEP, field_type'($urandom), field_type'($urandom),
                   1'($urandom));
         repeat ($urandom_range(4, 10)) begin
            rr = clip_index(r0 - 1 + $urandom_range(0, h + 1), ROWS);
            cc = clip_index(c0 - 1 + $urandom_range(0, w + 1), COLS);
            send_item(lge_pkg::KIND_READ, field_type'(rr), field_type'(cc),
                      1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count) begin
         send_item(kind_type'($urandom_range(0, 3)), field_type'($urandom),
                   field_type'($urandom), 1'($urandom));
      end
   endtask

   // reads along the borders, where wrap-around would show
   task automatic read_edges(input int count);
      int rr;
      int cc;
      repeat (count) begin
         rr = $urandom_range(0, ROWS - 1);
         cc = $urandom_range(0, COLS - 1);
         case ($urandom_range(0, 3))
            0: rr = 0;
            1: rr = ROWS - 1;
            2: cc = 0;
            default: cc = COLS - 1;
         endcase
         send_item(lge_pkg::KIND_READ, field_type'(rr), field_type'(cc),
                   1'($urandom_range(0, 1)));
      end
   endtask

   task automatic run_mixed_traffic(input int target);
      int pick;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            run_pattern_burst();
         end else if (pick < 18) begin
            send_noise($urandom_range(3, 8));
         end else begin
            read_edges($urandom_range(3, 8));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   task automatic test_directed_cases();
      // horizontal blinker on the top edge, plus the four corners
      send_item(lge_pkg::KIND_WRITE, 6'd0, 6'd0, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd0, 6'd1, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd0, 6'd2, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd63, 6'd63, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd63, 6'd0, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd0, 6'd63, 1'b1);
      send_item(lge_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd0, 6'd63, 1'b1);
      // unused kind must leave the cell alone
      send_item(KIND_UNUSED, 6'd5, 6'd5, 1'b1);
      send_item(lge_pkg::KIND_READ, 6'd5, 6'd5, 1'b0);
      send_item(KIND_UNUSED, 6'd63, 6'd63, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd63, 6'd63, 1'b0);
      send_item(lge_pkg::KIND_WRITE, 6'd63, 6'd63, 1'b0);
      send_item(lge_pkg::KIND_STEP, 6'd63, 6'd63, 1'b1);
      send_item(lge_pkg::KIND_READ, 6'd0, 6'd1, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd1, 6'd1, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd0, 6'd0, 1'b0);
      // no wrap to the bottom row or the far column
      send_item(lge_pkg::KIND_READ, 6'd63, 6'd1, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd0, 6'd62, 1'b0);
      send_item(lge_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd0, 6'd1, 1'b1);
      send_item(lge_pkg::KIND_READ, 6'd1, 6'd1, 1'b1);
      send_item(lge_pkg::KIND_READ, 6'd63, 6'd0, 1'b1);
   endtask

   task automatic test_random_patterns();
      run_mixed_traffic(ITEMS_RANDOM);
   endtask

   task automatic test_output_backpressure();
      hold_rsp_request = 1'b1;
      while (!hold_rsp_active) @(posedge clock);
      send_item(lge_pkg::KIND_WRITE, 6'd31, 6'd31, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd31, 6'd32, 1'b1);
      send_item(lge_pkg::KIND_WRITE, 6'd31, 6'd33, 1'b1);
      send_item(lge_pkg::KIND_STEP, 6'd0, 6'd0, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd30, 6'd32, 1'b0);
      send_item(lge_pkg::KIND_READ, 6'd32, 6'd32, 1'b0);
      send_noise(14);
   endtask

   task automatic test_steady_stream();
      idling_enabled = 1'b0;
      run_mixed_traffic(ITEMS_TOTAL);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_random_patterns();
      test_output_backpressure();
      test_steady_stream();

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run covered %0d transactions: %0d writes, %0d reads (%0d live cells), %0d steps",
               items_sent, writes_seen, reads_seen, live_reads, steps_seen);
      $display("unused kind %0d times, one long response hold-off, %0d errors",
               unused_seen, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
